// ----- rtl/rcsa_pkg.sv -----
package rcsa_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LOW_LIMIT     = 2'd0;
  localparam cfg_idx_t REG_HIGH_LIMIT    = 2'd1;
  localparam cfg_idx_t REG_TIMEOUT_TICKS = 2'd2;

  localparam logic signed [SampleW-1:0] LowLimitReset  = -16'sd500;
  localparam logic signed [SampleW-1:0] HighLimitReset = 16'sd1250;
  localparam logic [SampleW-1:0]        TimeoutReset   = 16'd90;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [SampleW-1:0] sample_value;
  } rcsa_in_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [SampleW-1:0] average;
    logic                      average_valid;
  } rcsa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_READ,
    ST_ACC,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } rcsa_state_e;

endpackage

// ----- rtl/rcsa_div.sv -----
module rcsa_div #(
  parameter int unsigned N_W = 19,
  parameter int unsigned D_W = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(N_W + 1);

  logic [N_W-1:0]   quo_q;
  logic [D_W-1:0]   rem_q;
  logic [D_W-1:0]   dvs_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;

  logic [D_W:0] rem_sh;
  logic [D_W:0] diff;
  logic         fit;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[N_W-1]};
  assign fit    = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(N_W);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N_W-2:0], fit};
      rem_q <= fit ? diff[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/range_checked_sample_averager.sv -----
// Range-checked moving average over a ring of DEPTH samples. An item is either a
// sample (func 0) or a time tick (func 1); each item yields exactly one result.
// A sample inside the inclusive limits is stored and reloads the inactivity
// countdown; a sample outside them empties the window, and so does the countdown
// running out through ticks. The block takes one transaction at a time: an item
// stays inside while the single sample memory read port fetches the N stored
// entries (a read state, then an accumulate state, each) and the bit-per-cycle
// divider works through the SUM_W = 17 + clog2(DEPTH) bit sum; an empty window
// skips both. Configuration must be written through the plain write port and
// only while no transaction is in flight; the block itself does not enforce it.
module range_checked_sample_averager
  import rcsa_pkg::*;
#(
  parameter int unsigned DEPTH = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rcsa_in_t     in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rcsa_out_t    out_data_o,
  input  logic         cfg_we_i,
  input  cfg_idx_t     cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = 17 + $clog2(DEPTH);

  logic signed [SampleW-1:0] low_limit_q;
  logic signed [SampleW-1:0] high_limit_q;
  logic [SampleW-1:0]        timeout_ticks_q;

  logic [SampleW-1:0] window_mem [DEPTH];
  logic [SampleW-1:0] rd_data_q;

  logic [IdxW-1:0]    wr_idx_q;
  logic               full_q;
  logic [SampleW-1:0] countdown_q;
  logic               armed_q;

  rcsa_state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic signed [SumW-1:0] sum_q;
  rcsa_out_t              out_q;

  logic            accept;
  logic            in_range;
  logic            rd_last;
  logic [CntW-1:0] count;
  logic            div_start;
  logic            div_done;
  logic [SumW-1:0] sum_mag;
  logic [SumW-1:0] quotient;
  logic [SampleW-1:0] q16;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = (in_data_i.sample_value >= low_limit_q) &&
                    (in_data_i.sample_value <= high_limit_q);
  assign count    = full_q ? CntW'(DEPTH) : CntW'(wr_idx_q);
  assign rd_last  = (CntW'(rd_idx_q) + CntW'(1)) == cnt_q;
  assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign q16      = quotient[SampleW-1:0];

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q     <= LowLimitReset;
      high_limit_q    <= HighLimitReset;
      timeout_ticks_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOW_LIMIT:     low_limit_q     <= cfg_data_i;
        REG_HIGH_LIMIT:    high_limit_q    <= cfg_data_i;
        REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample ring; only entries below the fill count are summed.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.func == FUNC_SAMPLE && in_range) begin
      window_mem[wr_idx_q] <= in_data_i.sample_value;
    end
    rd_data_q <= window_mem[rd_idx_q];
  end

  // Window and countdown state, updated once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      full_q      <= 1'b0;
      countdown_q <= '0;
      armed_q     <= 1'b0;
    end else if (accept) begin
      if (in_data_i.func == FUNC_SAMPLE) begin
        if (in_range) begin
          if (wr_idx_q == IdxW'(DEPTH - 1)) begin
            wr_idx_q <= '0;
            full_q   <= 1'b1;
          end else begin
            wr_idx_q <= wr_idx_q + IdxW'(1);
          end
          countdown_q <= timeout_ticks_q;
          armed_q     <= 1'b1;
        end else begin
          wr_idx_q <= '0;
          full_q   <= 1'b0;
        end
      end else if (armed_q) begin
        // A countdown of zero or one expires on this tick.
        if (countdown_q <= SampleW'(1)) begin
          countdown_q <= '0;
          armed_q     <= 1'b0;
          wr_idx_q    <= '0;
          full_q      <= 1'b0;
        end else begin
          countdown_q <= countdown_q - SampleW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_COUNT;
      ST_COUNT:     state_d = (count == '0) ? ST_OUT : ST_READ;
      ST_READ:      state_d = ST_ACC;
      ST_ACC:       state_d = rd_last ? ST_DIV_START : ST_READ;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_OUT;
      ST_OUT:       if (out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE:      in_ready_o  = 1'b1;
      ST_DIV_START: div_start   = 1'b1;
      ST_OUT:       out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Sum and result datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        out_q.accepted <= in_data_i.func == FUNC_SAMPLE && in_range;
      end
      ST_COUNT: begin
        cnt_q               <= count;
        rd_idx_q            <= '0;
        sum_q               <= '0;
        out_q.average       <= '0;
        out_q.average_valid <= count != '0;
      end
      ST_ACC: begin
        sum_q    <= sum_q + SumW'($signed(rd_data_q));
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      ST_DIV: begin
        if (div_done) begin
          out_q.average <= sum_q[SumW-1] ? -q16 : q16;
        end
      end
      default: ;
    endcase
  end

  rcsa_div #(
    .N_W(SumW),
    .D_W(CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_data_o = out_q;

endmodule

// ----- dv/tb_range_checked_sample_averager.sv -----
module tb_range_checked_sample_averager;
  import rcsa_pkg::*;

  localparam int WinDepth = 3;

  // Tracks the averaging window alongside the block and holds the results
  // still owed by it, oldest first.
  class window_scoreboard;
    logic signed [15:0] low_lim;
    logic signed [15:0] high_lim;
    logic [15:0]        timeout;
    logic signed [15:0] slots [WinDepth];
    int unsigned        wr_idx;
    bit                 full;
    logic [15:0]        countdown;
    bit                 armed;
    rcsa_out_t          pending_averages [$];
    int                 errors;

    function new();
      low_lim   = LowLimitReset;
      high_lim  = HighLimitReset;
      timeout   = TimeoutReset;
      wr_idx    = 0;
      full      = 1'b0;
      countdown = '0;
      armed     = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return pending_averages.size();
    endfunction

    function rcsa_out_t step_window(rcsa_in_t it);
      rcsa_out_t res;
      int        fill;
      int        total;
      int        i;
      res = '0;
      if (it.func == FUNC_SAMPLE) begin
        if (it.sample_value >= low_lim && it.sample_value <= high_lim) begin
          slots[wr_idx] = it.sample_value;
          wr_idx++;
          if (wr_idx >= WinDepth) begin
            wr_idx = 0;
            full   = 1'b1;
          end
          countdown    = timeout;
          armed        = 1'b1;
          res.accepted = 1'b1;
        end else begin
          wr_idx = 0;
          full   = 1'b0;
        end
      end else if (armed) begin
        // A reload of zero expires on the very next tick, like a reload of one.
        if (countdown <= 1) begin
          countdown = '0;
          armed     = 1'b0;
          wr_idx    = 0;
          full      = 1'b0;
        end else begin
          countdown--;
        end
      end
      fill  = full ? WinDepth : int'(wr_idx);
      total = 0;
      for (i = 0; i < fill; i++) total += slots[i];
      if (fill > 0) begin
        res.average       = 16'(total / fill);
        res.average_valid = 1'b1;
      end
      return res;
    endfunction

    function void note_item(rcsa_in_t it);
      pending_averages.push_back(step_window(it));
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_result(rcsa_out_t got);
      rcsa_out_t want;
      if (pending_averages.size() == 0) begin
        flag("result with nothing pending (average)", 0, int'(got.average));
        return;
      end
      want = pending_averages.pop_front();
      if (got.accepted !== want.accepted) begin
        flag("accepted", want.accepted, got.accepted);
      end
      if (got.average !== want.average) begin
        flag("average", int'(want.average), int'(got.average));
      end
      if (got.average_valid !== want.average_valid) begin
        flag("average_valid", want.average_valid, got.average_valid);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  rcsa_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  rcsa_out_t out_data_o;
  logic      cfg_we_i;
  cfg_idx_t  cfg_index_i;
  logic [15:0] cfg_data_i;

  window_scoreboard sb = new();
  bit long_hold_req = 1'b0;
  int burst_left = 0;

  range_checked_sample_averager #(
    .DEPTH(WinDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result is checked before the new transaction is noted, since a result
  // taken at the same edge always belongs to an earlier item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_item(in_data_i);
    end
  end

  initial begin
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((left % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send(input rcsa_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(1, 20);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_sample(input logic signed [15:0] v);
    rcsa_in_t it;
    it.func = FUNC_SAMPLE;
    it.sample_value = v;
    send(it);
  endtask

  task automatic send_tick();
    rcsa_in_t it;
    it.func = FUNC_TICK;
    it.sample_value = 16'($urandom_range(0, 65535));
    send(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_config(input logic signed [15:0] lo, input logic signed [15:0] hi,
                              input logic [15:0] tmo);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LOW_LIMIT;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_HIGH_LIMIT;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_index_i <= REG_TIMEOUT_TICKS;
    cfg_data_i  <= tmo;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.low_lim  = lo;
    sb.high_lim = hi;
    sb.timeout  = tmo;
  endtask

  task automatic run_phase(input int count, input int tick_pct, input bit with_pressure);
    rcsa_in_t it;
    int       pick;
    int       span;
    bit       ordered;
    for (int n = 0; n < count; n++) begin
      if (with_pressure && n == count / 3) long_hold_req = 1'b1;
      if (with_pressure && n == 2 * count / 3) drain_results();
      ordered = (sb.low_lim <= sb.high_lim);
      pick = $urandom_range(0, 99);
      it.func = FUNC_SAMPLE;
      it.sample_value = 16'($urandom_range(0, 65535));
      if (pick < tick_pct) begin
        it.func = FUNC_TICK;
      end else if (ordered && pick < 88) begin
        span = int'(sb.high_lim) - int'(sb.low_lim);
        it.sample_value = 16'(int'(sb.low_lim) + int'($urandom_range(0, span)));
      end else if (ordered && pick < 92) begin
        // Samples right on and just outside either limit.
        case ($urandom_range(0, 3))
          0: it.sample_value = sb.low_lim;
          1: it.sample_value = sb.high_lim;
          2: it.sample_value = sb.low_lim - 16'sd1;
          default: it.sample_value = sb.high_lim + 16'sd1;
        endcase
      end
      send(it);
    end
  endtask

  initial begin
    logic signed [15:0] lo;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_LOW_LIMIT;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Limits from reset: a tick on an empty window, both limit edges, samples
    // just outside them, a ring wrap and an overwrite of the oldest slot.
    send_tick();
    send_sample(-16'sd500);
    send_sample(16'sd1250);
    send_sample(16'sd1251);
    send_sample(-16'sd501);
    send_sample(16'sd100);
    send_sample(16'sd200);
    send_sample(16'sd301);
    send_sample(16'sd400);
    send_sample(-16'sd1);
    send_tick();
    send_sample(-16'sd32768);

    // Full range, short countdown: extreme sums, a negative mean truncated
    // toward zero and expiry through ticks.
    write_config(-16'sd32768, 16'sd32767, 16'd2);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(-16'sd32767);
    send_sample(16'sd32767);
    send_tick();
    send_tick();
    send_sample(-16'sd1);
    send_sample(-16'sd2);
    send_tick();

    // Crossed limits accept nothing.
    write_config(16'sd1, 16'sd0, 16'd0);
    send_sample(16'sd0);
    send_sample(16'sd1);

    // A zero reload expires on the first tick.
    write_config(-16'sd5, -16'sd5, 16'd0);
    send_sample(-16'sd5);
    send_tick();
    send_tick();

    write_config(-16'sd32768, 16'sd32767, 16'd1);
    run_phase(300, 30, 1'b0);

    lo = 16'($urandom_range(0, 1500) - 1000);
    write_config(lo, 16'(int'(lo) + int'($urandom_range(0, 1500))),
                 16'($urandom_range(1, 4)));
    run_phase(300, 40, 1'b0);

    lo = 16'($urandom_range(0, 65535));
    write_config(lo, lo, 16'd3);
    run_phase(300, 50, 1'b0);

    lo = 16'($urandom_range(0, 4000) - 2000);
    write_config(lo, 16'(int'(lo) + int'($urandom_range(0, 3000))), 16'd65535);
    run_phase(300, 20, 1'b1);

    lo = 16'($urandom_range(0, 2000) - 1000);
    write_config(lo, 16'(int'(lo) + int'($urandom_range(0, 2000))), 16'd0);
    run_phase(300, 60, 1'b0);

    write_config(-16'sd20000, 16'sd20000, 16'($urandom_range(2, 8)));
    run_phase(300, 50, 1'b0);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
